/* hw/rtl/thb_pkg.sv */
// ----------------------------------------------------------------------------
// thb_pkg: shared types and constants for the trochoid height solver
// Fixed-point formats, CORDIC arctangent table and the trig result bundle.
// ----------------------------------------------------------------------------
package thb_pkg;

    // bisection steps per item
    localparam int ITERATIONS   = 12;
    localparam int ITER_CNT_W   = $clog2(ITERATIONS + 1);

    // angles are unsigned Q2.14 radians
    localparam int ANG_W        = 16;
    localparam logic [ANG_W-1:0] ANG_PI      = 16'd51472;
    localparam logic [ANG_W-1:0] ANG_HALF_PI = 16'd25736;

    // cordic
    localparam int CORDIC_STEPS = 14;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CXY_W        = 18;
    localparam int CZ_W         = 17;
    localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 18'sd9949;
    localparam logic signed [CXY_W-1:0] ONE_Q14     = 18'sd16384;

    // trig values, signed Q1.14
    localparam int TRIG_W       = 16;

    // field and product widths
    localparam int FIELD_W      = 16;
    localparam int HEIGHT_W     = 17;
    localparam int MUL_W        = 17;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int VAL_W        = PROD_W + 1;
    localparam int HALF_HEIGHT_RESET = 256;
    localparam int HEIGHT_MAX   = 65535;
    localparam int ROUND_HALF   = 8192;
    localparam int FRAC_SHIFT   = 14;

    // result of one sine / cosine evaluation
    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] sin_q14;
        logic signed [TRIG_W-1:0] cos_q14;
    } thb_trig_t;

    // arctangent of 2^-i in Q2.14
    function automatic logic signed [CZ_W-1:0] atan_q14(input logic [STEP_W-1:0] idx);
        logic signed [CZ_W-1:0] r;
        case (idx)
            4'd0:    r = 17'sd12868;
            4'd1:    r = 17'sd7596;
            4'd2:    r = 17'sd4014;
            4'd3:    r = 17'sd2037;
            4'd4:    r = 17'sd1023;
            4'd5:    r = 17'sd512;
            4'd6:    r = 17'sd256;
            4'd7:    r = 17'sd128;
            4'd8:    r = 17'sd64;
            4'd9:    r = 17'sd32;
            4'd10:   r = 17'sd16;
            4'd11:   r = 17'sd8;
            4'd12:   r = 17'sd4;
            4'd13:   r = 17'sd2;
            default: r = 17'sd0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/thb_mult.sv */
// ----------------------------------------------------------------------------
// thb_mult: shared registered multiplier
// Signed 17 x 17 multiply with the product registered, used for every product.
// ----------------------------------------------------------------------------
module thb_mult
    import thb_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod_reg
);

    // one product per cycle
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

/* hw/rtl/thb_cordic.sv */
// ----------------------------------------------------------------------------
// thb_cordic: iterative sine and cosine
// Rotation-mode CORDIC, one micro-rotation a cycle, angles in [0, pi].
// ----------------------------------------------------------------------------
module thb_cordic
    import thb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ANG_W-1:0] angle,
    output logic             busy,
    output thb_trig_t        trig
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     upper_reg;
    logic signed [CXY_W-1:0]  x_reg, y_reg;
    logic signed [CZ_W-1:0]   z_reg;
    logic signed [TRIG_W-1:0] sin_reg, cos_reg;

    logic signed [CXY_W-1:0]  dx, dy, x_next, y_next, x_fold;
    logic signed [CZ_W-1:0]   z_next, atan_val;
    logic                     upper_in;
    logic [ANG_W-1:0]         z_start;

    // saturate to +-1.0 in Q1.14
    function automatic logic signed [TRIG_W-1:0] clamp_one(input logic signed [CXY_W-1:0] v);
        logic signed [CXY_W-1:0] r;
        if (v > ONE_Q14) begin
            r = ONE_Q14;
        end else if (v < -ONE_Q14) begin
            r = -ONE_Q14;
        end else begin
            r = v;
        end
        return r[TRIG_W-1:0];
    endfunction

    // fold angles above pi/2 onto pi - t
    assign upper_in = angle > ANG_HALF_PI;
    assign z_start  = upper_in ? ANG_PI - angle : angle;

    // one micro-rotation
    always_comb begin
        atan_val = atan_q14(step_reg);
        dx       = y_reg >>> step_reg;
        dy       = x_reg >>> step_reg;
        if (!z_reg[CZ_W-1]) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - atan_val;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + atan_val;
        end
        x_fold = upper_reg ? -x_next : x_next;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            x_reg     <= CORDIC_GAIN;
            y_reg     <= '0;
            z_reg     <= signed'({1'b0, z_start});
            upper_reg <= upper_in;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                sin_reg <= clamp_one(y_next);
                cos_reg <= clamp_one(x_fold);
            end
        end
    end

    assign busy         = busy_reg;
    assign trig.done    = done_reg;
    assign trig.sin_q14 = sin_reg;
    assign trig.cos_q14 = cos_reg;

endmodule

/* hw/rtl/trochoid_height_bisection.sv */
// ----------------------------------------------------------------------------
// trochoid_height_bisection: trochoid surface height by angle bisection
// Solves a*t - b*sin(t) = x over [0, pi] and returns b*cos(t).
// ----------------------------------------------------------------------------
// One item is taken at a time. Each of the 12 bisection steps forms the
// midpoint, runs the iterative CORDIC (one micro-rotation a cycle) and then
// uses the shared multiplier (a*t, b*sin(t), compare). The final b*cos(t)
// reuses the last CORDIC result and is rounded and saturated; the block then
// goes back to idle, where it takes the next item, and s_tready stays low
// from an acceptance until that return. The result sits in an output
// register, so a new item is accepted while the previous height still waits
// on m_tready; a second height finished before the first has left holds the
// block in its output state.
// half_height must only be written while the block is idle.
module trochoid_height_bisection
    import thb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // half_height
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // [15:0] wave_scale, [31:16] crest_distance
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata       // [16:0] height, [23:17] zero
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_MID     = 9'b000000010,
        S_TRIG    = 9'b000000100,
        S_MUL_A   = 9'b000001000,
        S_MUL_B   = 9'b000010000,
        S_DECIDE  = 9'b000100000,
        S_FIN_MUL = 9'b001000000,
        S_ROUND   = 9'b010000000,
        S_OUT     = 9'b100000000
    } thb_state_t;

    thb_state_t state_reg, state_next;

    logic [FIELD_W-1:0]       half_height_reg;
    logic [FIELD_W-1:0]       scale_reg, dist_reg;
    logic [ANG_W-1:0]         left_reg, right_reg, mid_reg;
    logic [ITER_CNT_W-1:0]    iter_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [HEIGHT_W-1:0]      height_reg;
    logic                     m_tvalid_reg;
    logic [23:0]              m_tdata_reg;

    logic [ANG_W:0]           mid_sum;
    logic [ANG_W-1:0]         mid_calc;
    logic                     cordic_busy;
    thb_trig_t                trig;
    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [VAL_W-1:0]  val, target, rsum, rshift;
    logic [HEIGHT_W-1:0]      height_sat;
    logic                     go_left, out_free;

    // midpoint of the current interval
    assign mid_sum  = {1'b0, left_reg} + {1'b0, right_reg};
    assign mid_calc = mid_sum[ANG_W:1];

    thb_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_MID),
        .angle   (mid_calc),
        .busy    (cordic_busy),
        .trig    (trig)
    );

    // operand selection for the shared multiplier
    always_comb begin
        case (state_reg)
            S_MUL_B: begin
                op_a = signed'({1'b0, half_height_reg});
                op_b = MUL_W'(trig.sin_q14);
            end
            S_FIN_MUL: begin
                op_a = signed'({1'b0, half_height_reg});
                op_b = MUL_W'(trig.cos_q14);
            end
            default: begin
                op_a = signed'({1'b0, scale_reg});
                op_b = signed'({1'b0, mid_reg});
            end
        endcase
    end

    thb_mult u_mult (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod)
    );

    // bisection compare: x << 14 against a*t - b*sin(t)
    assign val     = VAL_W'(acc_reg) - VAL_W'(prod);
    assign target  = signed'({(VAL_W - FIELD_W - FRAC_SHIFT)'(0), dist_reg, FRAC_SHIFT'(0)});
    assign go_left = target > val;

    // round half up and saturate the height
    always_comb begin
        rsum   = VAL_W'(prod) + VAL_W'(ROUND_HALF);
        rshift = rsum >>> FRAC_SHIFT;
        if (rshift > VAL_W'(HEIGHT_MAX)) begin
            height_sat = HEIGHT_W'(HEIGHT_MAX);
        end else if (rshift < -VAL_W'(HEIGHT_MAX)) begin
            height_sat = HEIGHT_W'(-HEIGHT_MAX);
        end else begin
            height_sat = rshift[HEIGHT_W-1:0];
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_MID;
            S_MID:     state_next = S_TRIG;
            S_TRIG:    if (trig.done) state_next = S_MUL_A;
            S_MUL_A:   state_next = S_MUL_B;
            S_MUL_B:   state_next = S_DECIDE;
            S_DECIDE: begin
                if (iter_reg == ITER_CNT_W'(ITERATIONS - 1)) begin
                    state_next = S_FIN_MUL;
                end else begin
                    state_next = S_MID;
                end
            end
            S_FIN_MUL: state_next = S_ROUND;
            S_ROUND:   state_next = S_OUT;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            half_height_reg <= FIELD_W'(HALF_HEIGHT_RESET);
            m_tvalid_reg    <= 1'b0;
            iter_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                half_height_reg <= cfg_wr_data;
            end
            if (state_reg == S_IDLE) begin
                iter_reg <= '0;
            end else if (state_reg == S_DECIDE) begin
                iter_reg <= iter_reg + 1'b1;
            end
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                scale_reg <= s_tdata[15:0];
                dist_reg  <= s_tdata[31:16];
                left_reg  <= '0;
                right_reg <= ANG_PI;
            end
            S_MID: mid_reg <= mid_calc;
            S_MUL_B: acc_reg <= prod;
            S_DECIDE: begin
                if (go_left) begin
                    left_reg <= mid_reg;
                end else begin
                    right_reg <= mid_reg;
                end
            end
            S_ROUND: height_reg <= height_sat;
            S_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {7'd0, height_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in work");

    a_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE) |-> (left_reg <= mid_reg && mid_reg <= right_reg))
        else $error("midpoint outside the bisection interval");

    a_trig_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        trig.done |-> (state_reg == S_TRIG && !cordic_busy))
        else $error("cordic finished outside the trig wait");

    a_height_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:0] != 17'h10000 && m_tdata[23:17] == 7'd0))
        else $error("height outside the saturated range");

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for trochoid_height_bisection
// Drives (wave_scale, crest_distance) items through the stream input, predicts
// each height with an independent bisection and CORDIC model, and compares
// every result item in order. Covers half_height settings, back-pressure and
// sender pauses.
// ----------------------------------------------------------------------------
module tb
    import thb_pkg::*;
();

    localparam int  STUCK_LIMIT = 4000;
    localparam int  TAIL_CYCLES = 300;
    localparam int  EXP_DEPTH   = 16;
    localparam longint UNIT_Q14 = 16384;
    localparam longint ROT_GAIN = 9949;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // [15:0] wave_scale, [31:16] crest_distance
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;      // [16:0] height, [23:17] zero

    // arctangent of 2^-i, Q2.14 radians
    longint      arctan_steps [0:13] = '{12868, 7596, 4014, 2037, 1023, 512, 256,
                                         128, 64, 32, 16, 8, 4, 2};

    // ring of predicted heights, oldest first
    logic [16:0] expected_heights [0:EXP_DEPTH-1];
    int          exp_wr_count;
    int          exp_rd_count;
    logic [15:0] half_height_cfg;
    int          mismatches;
    int          stuck_cycles;
    int          rx_hold;
    int          rx_wait;
    bit          idle_on;

    trochoid_height_bisection uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // sine and cosine of an angle in [0, pi], Q2.14 in, Q1.14 out
    function automatic void trig_at(input int unsigned ang, output longint sin_v,
                                    output longint cos_v);
        longint cx, cy, cz, dx, dy;
        bit     upper;
        upper = ang > ANG_HALF_PI;
        cz = upper ? longint'(ANG_PI) - longint'(ang) : longint'(ang);
        cx = ROT_GAIN;
        cy = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
                cx -= dx;
                cy += dy;
                cz -= arctan_steps[i];
            end else begin
                cx += dx;
                cy -= dy;
                cz += arctan_steps[i];
            end
        end
        // upper quadrant mirrors the cosine
        if (upper)
            cx = -cx;
        sin_v = (cy > UNIT_Q14) ? UNIT_Q14 : ((cy < -UNIT_Q14) ? -UNIT_Q14 : cy);
        cos_v = (cx > UNIT_Q14) ? UNIT_Q14 : ((cx < -UNIT_Q14) ? -UNIT_Q14 : cx);
    endfunction

    // surface height b*cos(t) for a*t - b*sin(t) = x
    function automatic logic [16:0] trochoid_height(input logic [15:0] scale,
                                                    input logic [15:0] crest,
                                                    input logic [15:0] b);
        longint      target, val, s, c, h, la, lb;
        int unsigned lo, hi, mid;
        la = scale;
        lb = b;
        target = longint'(crest) * UNIT_Q14;
        lo = 0;
        hi = ANG_PI;
        mid = 0;
        for (int i = 0; i < ITERATIONS; i++) begin
            mid = (lo + hi) >> 1;
            trig_at(mid, s, c);
            val = la * longint'(mid) - lb * s;
            if (target > val)
                lo = mid;
            else
                hi = mid;
        end
        trig_at(mid, s, c);
        h = (lb * c + 8192) >>> 14;
        if (h > HEIGHT_MAX)
            h = HEIGHT_MAX;
        else if (h < -HEIGHT_MAX)
            h = -HEIGHT_MAX;
        return h[16:0];
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("[%0t] mismatch %s: expected %0d, got %0d", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    // result side: check each item, then hold off at random while idle_on is set
    initial begin
        m_tready = 1'b0;
        rx_wait = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (exp_rd_count == exp_wr_count) begin
                    report_mismatch("result with none expected", 0,
                                    $signed(m_tdata[16:0]));
                end else begin
                    logic [16:0] want;
                    want = expected_heights[exp_rd_count % EXP_DEPTH];
                    exp_rd_count++;
                    if (m_tdata[16:0] !== want)
                        report_mismatch("height", $signed(want), $signed(m_tdata[16:0]));
                    if (m_tdata[23:17] !== 7'd0)
                        report_mismatch("tdata padding", 0, m_tdata[23:17]);
                end
                rx_wait = idle_on ? $urandom_range(0, 6) : 0;
            end
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // offer one item, return just after the accepting edge with tvalid still high
    task automatic send_item(input logic [15:0] scale, input logic [15:0] crest);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata  <= {crest, scale};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_heights[exp_wr_count % EXP_DEPTH] =
            trochoid_height(scale, crest, half_height_cfg);
        exp_wr_count++;
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // wait for every outstanding height
    task automatic wait_drain();
        idle_input();
        while (exp_rd_count != exp_wr_count)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_half_height(input logic [15:0] value);
        wait_drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        half_height_cfg = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly distances on the curve, some anywhere, some extremes
    task automatic send_random_item();
        logic [15:0] scale, crest;
        int unsigned lim;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                scale = 16'($urandom);
                lim = (int'(scale) * 201) >> 6;
                if (lim > 65535)
                    lim = 65535;
                crest = 16'($urandom_range(0, lim));
            end
            6, 7: begin
                scale = 16'($urandom);
                crest = 16'($urandom);
            end
            8: begin
                scale = 16'($urandom_range(0, 255));
                crest = 16'($urandom);
            end
            default: begin
                scale = 16'($urandom);
                crest = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
        endcase
        send_item(scale, crest);
    endtask

    // field extremes, both quadrants, clamping, saturation, far distance
    task automatic test_directed();
        idle_on = 1'b1;
        // reset value of half_height in use here
        send_item(16'h0000, 16'h0000);
        send_item(16'hFFFF, 16'hFFFF);
        send_item(16'h0000, 16'hFFFF);
        send_item(16'hFFFF, 16'h0000);
        send_item(16'h0001, 16'hFFFF);
        send_item(16'h0100, 16'h0000);
        send_item(16'h0100, 16'h0080);
        send_item(16'h0100, 16'd402);
        send_item(16'h0100, 16'd600);
        send_item(16'h0100, 16'd804);
        send_item(16'h0100, 16'h8000);
        send_item(16'h8000, 16'h8000);
        send_item(16'h00FF, 16'hFF00);
        send_item(16'hFF00, 16'h00FF);
        send_item(16'hAAAA, 16'h5555);
        send_item(16'h5555, 16'hAAAA);
        // largest half height, saturation corner
        write_half_height(16'hFFFF);
        send_item(16'hFFFF, 16'h0000);
        send_item(16'h0000, 16'h0000);
        send_item(16'h0100, 16'h0000);
        send_item(16'h4000, 16'h7000);
        // zero half height
        write_half_height(16'h0000);
        send_item(16'h0100, 16'd100);
        send_item(16'hFFFF, 16'hFFFF);
    endtask

    // a spread of register settings, each with random items
    task automatic test_config_sweep();
        logic [15:0] settings [0:6];
        settings = '{16'h0001, 16'h8000, 16'h00FF, 16'hFF00, 16'h0000, 16'hFFFF, 16'h0000};
        settings[4] = 16'($urandom);
        foreach (settings[k]) begin
            write_half_height(settings[k]);
            idle_on = (k % 2) == 0;
            repeat (30) send_random_item();
        end
    endtask

    // bulk random items, fresh half height per batch
    task automatic test_random();
        for (int batch = 0; batch < 14; batch++) begin
            if ($urandom_range(0, 3) == 0)
                write_half_height(16'($urandom_range(0, 16'h0300)));
            else
                write_half_height(16'($urandom));
            idle_on = $urandom_range(0, 3) != 0;
            repeat (100) send_random_item();
        end
    endtask

    // result side stalls long enough for the input to back up
    task automatic test_receiver_holdoff();
        write_half_height(16'($urandom));
        idle_on = 1'b0;
        rx_hold = 1000;
        repeat (12) send_random_item();
        idle_on = 1'b1;
    endtask

    // sender stops until every height is back, then resumes
    task automatic test_sender_pause();
        idle_on = 1'b1;
        repeat (10) send_random_item();
        wait_drain();
        repeat (10) send_random_item();
    endtask

    // sequence
    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 16'h0000;
        s_tvalid        = 1'b0;
        s_tdata         = 32'h0;
        half_height_cfg = 16'd256;
        exp_wr_count    = 0;
        exp_rd_count    = 0;
        mismatches      = 0;
        stuck_cycles    = 0;
        rx_hold         = 0;
        idle_on         = 1'b1;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_config_sweep();
        test_random();
        test_receiver_holdoff();
        test_sender_pause();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && exp_rd_count == exp_wr_count) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
